>>> rtl/jpp_pkg.sv
// ----------------------------------------------------------------------------
// JSON pretty printer package
// Shared widths, character codes, byte classes and the command and status
// structs that join the controller and the datapath.
// ----------------------------------------------------------------------------
package jpp_pkg;

  // nesting depth and indent run counter widths (run is two spaces per level)
  localparam int DEPTH_W = 5;
  localparam int CNT_W   = DEPTH_W + 1;

  typedef logic [7:0] char_t;

  // characters the formatter looks at or produces
  localparam char_t CH_LBRACE = 8'h7B;
  localparam char_t CH_RBRACE = 8'h7D;
  localparam char_t CH_LBRACK = 8'h5B;
  localparam char_t CH_RBRACK = 8'h5D;
  localparam char_t CH_COMMA  = 8'h2C;
  localparam char_t CH_COLON  = 8'h3A;
  localparam char_t CH_BSLASH = 8'h5C;
  localparam char_t CH_QUOTE  = 8'h22;
  localparam char_t CH_SPACE  = 8'h20;
  localparam char_t CH_TAB    = 8'h09;
  localparam char_t CH_LF     = 8'h0A;
  localparam char_t CH_CR     = 8'h0D;

  // class of an incoming byte
  typedef logic [2:0] cls_t;
  localparam cls_t CLS_COPY  = 3'd0;
  localparam cls_t CLS_DROP  = 3'd1;
  localparam cls_t CLS_OPEN  = 3'd2;
  localparam cls_t CLS_CLOSE = 3'd3;
  localparam cls_t CLS_COMMA = 3'd4;
  localparam cls_t CLS_COLON = 3'd5;

  // source of an output byte
  typedef logic [1:0] sel_t;
  localparam sel_t SEL_IN   = 2'd0;
  localparam sel_t SEL_HELD = 2'd1;
  localparam sel_t SEL_NL   = 2'd2;
  localparam sel_t SEL_SP   = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic take;     // input transfer this cycle
    logic emit;     // load the output register
    sel_t sel;      // byte source for the output register
    logic last;     // final byte of this input's run
    logic cnt_dec;  // one indent space consumed
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    cls_t cls;       // class of the byte at the input port
    logic nd_zero;   // depth after this byte is zero
    logic cnt_zero;  // indent run counter is zero
    logic cnt_one;   // one indent space left
    logic out_free;  // output register can take a byte this cycle
  } dp_stat_t;

endpackage

>>> rtl/json_pretty_printer_unit.sv
// ----------------------------------------------------------------------------
// JSON pretty printer
// Streaming re-indenter: two spaces of indent per nesting level.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel  (in_valid / in_stall): one JSON text byte per transfer, with
//   start_doc set on the first byte of a document to clear string, escape and
//   depth state. Output channel (out_valid / out_stall): one formatted byte per
//   transfer; run_last marks the final byte caused by an input byte. Input
//   whitespace outside strings produces no output transfer.
//   The first output byte is registered from the input transfer and is valid
//   in the next cycle. Ordinary bytes pass at one per cycle while the output
//   is not stalled. A structural byte holds off input for its run: opening
//   bracket and comma send the byte, a newline and two spaces per level of the
//   new depth; a closing bracket sends a newline, that indent, then itself; a
//   colon sends itself and a space. All go through the single output register.
//   When the receiver stalls, the output register holds its byte and the run
//   pauses; input is stalled until the run can continue. Reset (rst,
//   synchronous) returns the controller to idle, empties the output register
//   and clears all parsing state.
// ----------------------------------------------------------------------------
module json_pretty_printer_unit #(
  parameter int MAX_DEPTH = 30
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] text_byte,
  input  logic       start_doc,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       run_last
);

  jpp_pkg::dp_cmd_t  cmd;
  jpp_pkg::dp_stat_t stat;

  // run sequencer
  jpp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // classification, state and output register
  jpp_datapath #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .text_byte (text_byte),
    .start_doc (start_doc),
    .cmd       (cmd),
    .stat      (stat),
    .out_byte  (out_byte),
    .run_last  (run_last),
    .out_valid (out_valid),
    .out_stall (out_stall)
  );

endmodule

>>> rtl/jpp_datapath.sv
// ----------------------------------------------------------------------------
// JSON pretty printer datapath
// Byte classification, string/escape/depth state, indent run counter,
// held byte and output register.
// ----------------------------------------------------------------------------
module jpp_datapath #(
  parameter int MAX_DEPTH = 30
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [7:0]            text_byte,
  input  logic                  start_doc,
  input  jpp_pkg::dp_cmd_t      cmd,
  output jpp_pkg::dp_stat_t     stat,
  output logic [7:0]            out_byte,
  output logic                  run_last,
  output logic                  out_valid,
  input  logic                  out_stall
);

  localparam logic [jpp_pkg::DEPTH_W-1:0] DEPTH_MAX = jpp_pkg::DEPTH_W'(MAX_DEPTH);

  logic                         inside_string, inside_string_next;
  logic                         escape_pending, escape_pending_next;
  logic [jpp_pkg::DEPTH_W-1:0]  nest_depth, nest_depth_next;
  logic [jpp_pkg::CNT_W-1:0]    run_cnt;
  logic [7:0]                   held_byte;

  logic                         str_eff, esc_eff;
  logic [jpp_pkg::DEPTH_W-1:0]  depth_eff;
  jpp_pkg::cls_t                cls;
  logic [7:0]                   emit_byte;

  // start of document clears the state ahead of this byte
  assign str_eff   = start_doc ? 1'b0 : inside_string;
  assign esc_eff   = start_doc ? 1'b0 : escape_pending;
  assign depth_eff = start_doc ? '0 : nest_depth;

  // classify the byte and work out the state it leaves
  always_comb begin
    cls                 = jpp_pkg::CLS_COPY;
    inside_string_next  = str_eff;
    escape_pending_next = 1'b0;
    nest_depth_next     = depth_eff;
    if (esc_eff) begin
      cls = jpp_pkg::CLS_COPY;
    end else if (text_byte == jpp_pkg::CH_BSLASH) begin
      escape_pending_next = 1'b1;
    end else if (text_byte == jpp_pkg::CH_QUOTE) begin
      inside_string_next = !str_eff;
    end else if (str_eff) begin
      cls = jpp_pkg::CLS_COPY;
    end else if (text_byte inside {jpp_pkg::CH_LBRACE, jpp_pkg::CH_LBRACK}) begin
      cls = jpp_pkg::CLS_OPEN;
      if (depth_eff < DEPTH_MAX) begin
        nest_depth_next = depth_eff + 1'b1;
      end
    end else if (text_byte inside {jpp_pkg::CH_RBRACE, jpp_pkg::CH_RBRACK}) begin
      cls = jpp_pkg::CLS_CLOSE;
      if (depth_eff != '0) begin
        nest_depth_next = depth_eff - 1'b1;
      end
    end else if (text_byte == jpp_pkg::CH_COMMA) begin
      cls = jpp_pkg::CLS_COMMA;
    end else if (text_byte == jpp_pkg::CH_COLON) begin
      cls = jpp_pkg::CLS_COLON;
    end else if (text_byte inside {jpp_pkg::CH_SPACE, jpp_pkg::CH_TAB,
                                   jpp_pkg::CH_LF, jpp_pkg::CH_CR}) begin
      cls = jpp_pkg::CLS_DROP;
    end
  end

  // status back to the controller
  assign stat.cls      = cls;
  assign stat.nd_zero  = (nest_depth_next == '0);
  assign stat.cnt_zero = (run_cnt == '0);
  assign stat.cnt_one  = (run_cnt == jpp_pkg::CNT_W'(1));
  assign stat.out_free = !out_valid || !out_stall;

  // parsing state
  always_ff @(posedge clk) begin
    if (rst) begin
      inside_string  <= 1'b0;
      escape_pending <= 1'b0;
      nest_depth     <= '0;
    end else if (cmd.take) begin
      inside_string  <= inside_string_next;
      escape_pending <= escape_pending_next;
      nest_depth     <= nest_depth_next;
    end
  end

  // indent run counter: two spaces per level of the new depth
  always_ff @(posedge clk) begin
    if (rst) begin
      run_cnt <= '0;
    end else if (cmd.take) begin
      run_cnt <= {nest_depth_next, 1'b0};
    end else if (cmd.cnt_dec) begin
      run_cnt <= run_cnt - 1'b1;
    end
  end

  // byte kept for a closing bracket that goes out after its indent
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      held_byte <= text_byte;
    end
  end

  // output byte select
  always_comb begin
    case (cmd.sel)
      jpp_pkg::SEL_IN:   emit_byte = text_byte;
      jpp_pkg::SEL_HELD: emit_byte = held_byte;
      jpp_pkg::SEL_NL:   emit_byte = jpp_pkg::CH_LF;
      jpp_pkg::SEL_SP:   emit_byte = jpp_pkg::CH_SPACE;
      default:           emit_byte = jpp_pkg::CH_SPACE;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_byte <= emit_byte;
      run_last <= cmd.last;
    end
  end

  // a new byte never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || !out_stall))
    else $error("output register overwritten while stalled");

  // the indent counter never wraps
  a_cnt_no_wrap: assert property (@(posedge clk) disable iff (rst)
    (cmd.cnt_dec && !cmd.take) |-> (run_cnt != '0))
    else $error("indent counter decremented at zero");

  // depth stays within its bound
  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    nest_depth <= DEPTH_MAX)
    else $error("nesting depth beyond its maximum");

endmodule

>>> rtl/jpp_ctrl.sv
// ----------------------------------------------------------------------------
// JSON pretty printer controller
// Sequences the output run of one input byte: the byte itself, newline,
// indent spaces, closing bracket or colon space, at most one byte per cycle.
// ----------------------------------------------------------------------------
module jpp_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  jpp_pkg::dp_stat_t     stat,
  output jpp_pkg::dp_cmd_t      cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_NL   = 3'd1;
  localparam logic [2:0] S_IND  = 3'd2;
  localparam logic [2:0] S_CHR  = 3'd3;
  localparam logic [2:0] S_SPC  = 3'd4;

  logic [2:0] state, state_next;
  logic       close_pend, close_pend_next;

  // new input only between runs and when the output register has room
  assign in_stall = !((state == S_IDLE) && stat.out_free);

  always_comb begin
    state_next      = state;
    close_pend_next = close_pend;
    cmd.take        = 1'b0;
    cmd.emit        = 1'b0;
    cmd.sel         = jpp_pkg::SEL_IN;
    cmd.last        = 1'b0;
    cmd.cnt_dec     = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid && stat.out_free) begin
          cmd.take        = 1'b1;
          close_pend_next = (stat.cls == jpp_pkg::CLS_CLOSE);
          case (stat.cls)
            jpp_pkg::CLS_COPY: begin
              cmd.emit = 1'b1;
              cmd.last = 1'b1;
            end
            jpp_pkg::CLS_DROP: begin
              cmd.emit = 1'b0;
            end
            jpp_pkg::CLS_COLON: begin
              cmd.emit   = 1'b1;
              state_next = S_SPC;
            end
            jpp_pkg::CLS_OPEN, jpp_pkg::CLS_COMMA: begin
              cmd.emit   = 1'b1;
              state_next = S_NL;
            end
            jpp_pkg::CLS_CLOSE: begin
              cmd.emit   = 1'b1;
              cmd.sel    = jpp_pkg::SEL_NL;
              state_next = stat.nd_zero ? S_CHR : S_IND;
            end
            default: begin
              cmd.emit = 1'b1;
              cmd.last = 1'b1;
            end
          endcase
        end
      end
      // newline after an opening bracket or comma
      S_NL: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          cmd.sel    = jpp_pkg::SEL_NL;
          cmd.last   = stat.cnt_zero;
          state_next = stat.cnt_zero ? S_IDLE : S_IND;
        end
      end
      // indent spaces
      S_IND: begin
        if (stat.out_free) begin
          cmd.emit    = 1'b1;
          cmd.sel     = jpp_pkg::SEL_SP;
          cmd.cnt_dec = 1'b1;
          if (stat.cnt_one) begin
            cmd.last   = !close_pend;
            state_next = close_pend ? S_CHR : S_IDLE;
          end
        end
      end
      // closing bracket after its indent
      S_CHR: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          cmd.sel    = jpp_pkg::SEL_HELD;
          cmd.last   = 1'b1;
          state_next = S_IDLE;
        end
      end
      // space after a colon
      S_SPC: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          cmd.sel    = jpp_pkg::SEL_SP;
          cmd.last   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      close_pend <= 1'b0;
    end else begin
      state      <= state_next;
      close_pend <= close_pend_next;
    end
  end

  // a run ends with a last byte exactly when the controller returns to idle
  a_last_to_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && cmd.last) |=> (state == S_IDLE))
    else $error("last byte emitted without ending the run");

  // input is taken only between runs
  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.take |-> (state == S_IDLE))
    else $error("input taken during an output run");

  // the held bracket goes out only for a closing bracket
  a_held_close: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && (cmd.sel == jpp_pkg::SEL_HELD)) |-> close_pend)
    else $error("held byte emitted outside a closing run");

endmodule
